FILE: rtl/core/pnmenc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnmenc_pkg
// Shared types, character codes and register map of the plain-text raster
// sample encoder.
// ----------------------------------------------------------------------------
package pnmenc_pkg;

  // depth of the item queue between front and back end
  localparam int QUEUE_DEPTH = 4;

  // depth mode codes
  localparam logic [1:0] MODE_BIT   = 2'd0;
  localparam logic [1:0] MODE_DEC8  = 2'd1;
  localparam logic [1:0] MODE_DEC16 = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] DEPTH_MODE_RESET = MODE_DEC8;

  // register map
  localparam int         ADDR_W         = 3;
  localparam logic       REG_DEPTH_MODE = 1'b0;

  // output characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // classified sample handed from front to back end
  typedef struct packed {
    logic [15:0] value;     // value to print in decimal
    logic [2:0]  top_pos;   // position of the leading digit
    logic        has_text;  // digits and space are written
    logic        line_end;  // newline follows
  } item_t;

  // power of ten for one digit position
  function automatic logic [16:0] pow10(input logic [2:0] pos);
    logic [16:0] p;
    unique case (pos)
      3'd0:    p = 17'd1;
      3'd1:    p = 17'd10;
      3'd2:    p = 17'd100;
      3'd3:    p = 17'd1000;
      3'd4:    p = 17'd10000;
      default: p = 17'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/plain_pnm_sample_text_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plain_pnm_sample_text_encoder
// Turns image samples into the characters of a plain-text PNM raster line.
// ----------------------------------------------------------------------------
// Each sample gives its characters on the result side one per cycle while
// the output is popped: the decimal digits (or the single bit character in
// one-bit mode), a space, and a newline when the sample closes a scanline,
// and the character sequencer sets the rate. The front end takes one sample
// per cycle while its queue (QueueDepth words) has room, so the sequencer
// goes from one sample to the next without a gap. A sample in the unused
// depth mode gives only a newline, or no characters at all without line end.
// ----------------------------------------------------------------------------
module plain_pnm_sample_text_encoder import pnmenc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  // sample input
  input  wire logic              push,
  output logic                   full,
  input  wire logic [15:0]       sample_value,
  input  wire logic              line_end,
  // character output
  output logic                   empty,
  input  wire logic              pop,
  output logic      [7:0]        text_char,
  output logic                   run_last
);

  logic [1:0] depth_mode;
  logic       q_valid;
  logic       q_pop;
  item_t      q_item;

  // configuration registers
  pnmenc_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .depth_mode (depth_mode)
  );

  // sample classification and queue
  pnmenc_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .depth_mode   (depth_mode),
    .push         (push),
    .sample_value (sample_value),
    .line_end     (line_end),
    .full         (full),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  // character sequencer
  pnmenc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .text_char (text_char),
    .run_last  (run_last)
  );

  // a newline always closes the sample
  a_nl_is_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (text_char == CH_NL)) |-> run_last)
    else $error("newline not flagged as last character");

  // the last character of a sample is a separator
  a_last_is_sep: assert property (@(posedge clk) disable iff (rst)
    (!empty && run_last) |-> ((text_char == CH_SPACE) || (text_char == CH_NL)))
    else $error("last character is not a separator");

  // queue drains on the sequencer side only when it holds a word
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue read while empty");

endmodule
`default_nettype wire

FILE: rtl/core/pnmenc_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnmenc_regs
// APB-style configuration register block holding the depth mode.
// ----------------------------------------------------------------------------
module pnmenc_regs import pnmenc_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  output logic      [1:0]        depth_mode
);

  logic reg_index;
  logic wr_en;

  // word index from the byte address
  assign reg_index = paddr[2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;

  // depth mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      depth_mode <= DEPTH_MODE_RESET;
    end else if (wr_en && (reg_index == REG_DEPTH_MODE)) begin
      depth_mode <= pwdata[1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_index == REG_DEPTH_MODE) begin
      prdata = {30'd0, depth_mode};
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pnmenc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnmenc_front
// Accepts samples, classifies them by depth mode and digit count, and queues
// them for the character sequencer.
// ----------------------------------------------------------------------------
module pnmenc_front import pnmenc_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [1:0]  depth_mode,
  input  wire logic        push,
  input  wire logic [15:0] sample_value,
  input  wire logic        line_end,
  output logic             full,
  output logic             q_valid,
  output item_t            q_item,
  input  wire logic        q_pop
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t            slots [QueueDepth];
  logic [PtrW-1:0]  head;
  logic [PtrW-1:0]  tail;
  logic [CntW-1:0]  count;
  item_t            cls;
  logic [15:0]      dec_value;
  logic [2:0]       dec_pos;
  logic             accept;
  logic             wr;

  // value seen in decimal modes and its leading digit position
  always_comb begin
    dec_value = (depth_mode == MODE_DEC16) ? sample_value : {8'd0, sample_value[7:0]};
    if (dec_value >= 16'd10000) begin
      dec_pos = 3'd4;
    end else if (dec_value >= 16'd1000) begin
      dec_pos = 3'd3;
    end else if (dec_value >= 16'd100) begin
      dec_pos = 3'd2;
    end else if (dec_value >= 16'd10) begin
      dec_pos = 3'd1;
    end else begin
      dec_pos = 3'd0;
    end
  end

  // classify: a one-bit sample is a single decimal digit 0 or 1
  always_comb begin
    cls.line_end = line_end;
    unique case (depth_mode) inside
      MODE_BIT: begin
        cls.value    = {15'd0, (sample_value[7:0] == 8'd0)};
        cls.top_pos  = 3'd0;
        cls.has_text = 1'b1;
      end
      MODE_DEC8, MODE_DEC16: begin
        cls.value    = dec_value;
        cls.top_pos  = dec_pos;
        cls.has_text = 1'b1;
      end
      default: begin
        cls.value    = '0;
        cls.top_pos  = 3'd0;
        cls.has_text = 1'b0;
      end
    endcase
  end

  // items that make no character are dropped here
  assign accept  = push && !full;
  assign wr      = accept && (cls.has_text || cls.line_end);
  assign full    = (count == CntW'(QueueDepth));
  assign q_valid = (count != '0);
  assign q_item  = slots[head];

  // queue storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= cls;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= (tail == PtrW'(QueueDepth - 1)) ? '0 : tail + 1'b1;
      end
      if (q_pop) begin
        head <= (head == PtrW'(QueueDepth - 1)) ? '0 : head + 1'b1;
      end
      case ({wr, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/pnmenc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnmenc_back
// Character sequencer: writes the digits of one queued item most significant
// first, then the space and, at a line end, the newline, one character per
// cycle into the output register while it is free or popped.
// ----------------------------------------------------------------------------
module pnmenc_back import pnmenc_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire item_t      q_item,
  output logic            q_pop,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      text_char,
  output logic            run_last
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIGIT,
    PH_SPACE,
    PH_NL
  } phase_t;

  phase_t      state;
  logic        out_valid;
  logic [15:0] rem;
  logic [2:0]  pos;
  logic        nl;
  logic [16:0] pw;
  logic [16:0] thr;
  logic [16:0] sub;
  logic [3:0]  dig;
  logic [7:0]  ch;
  logic        lst;
  logic        adv;
  logic        emit;
  logic        done;
  logic        load;

  // current digit by compare against the multiples of the position weight
  always_comb begin
    pw  = pow10(pos);
    dig = 4'd0;
    sub = '0;
    thr = '0;
    for (int j = 1; j <= 9; j++) begin
      thr = 17'(pw * 17'(j));
      if ({1'b0, rem} >= thr) begin
        dig = 4'(j);
        sub = thr;
      end
    end
  end

  // character for the current phase
  always_comb begin
    case (state)
      PH_DIGIT: begin
        ch  = CH_ZERO + {4'd0, dig};
        lst = 1'b0;
      end
      PH_SPACE: begin
        ch  = CH_SPACE;
        lst = !nl;
      end
      PH_NL: begin
        ch  = CH_NL;
        lst = 1'b1;
      end
      default: begin
        ch  = CH_SPACE;
        lst = 1'b0;
      end
    endcase
  end

  // next item loads in the cycle the last character of this one goes out
  assign adv   = !out_valid || pop;
  assign emit  = (state != PH_IDLE) && adv;
  assign done  = emit && lst;
  assign load  = q_valid && ((state == PH_IDLE) || done);
  assign q_pop = load;
  assign empty = !out_valid;

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        text_char <= ch;
        run_last  <= lst;
      end else if (pop) begin
        out_valid <= 1'b0;
      end

      if (load) begin
        state <= q_item.has_text ? PH_DIGIT : PH_NL;
        rem   <= q_item.value;
        pos   <= q_item.top_pos;
        nl    <= q_item.line_end;
      end else if (emit) begin
        unique case (state)
          PH_DIGIT: begin
            rem <= rem - sub[15:0];
            if (pos == 3'd0) begin
              state <= PH_SPACE;
            end else begin
              pos <= pos - 1'b1;
            end
          end
          PH_SPACE: state <= nl ? PH_NL : PH_IDLE;
          PH_NL:    state <= PH_IDLE;
          default:  state <= PH_IDLE;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
